FILE: sv/vpu_pkg.sv
`timescale 1ns / 1ps

package vpu_pkg;

	localparam int DEF_COMPONENT_WIDTH = 20;
	localparam int DEF_FRACTION_BITS   = 12;

	// step weights and relaxation fraction
	localparam int STEP_FRAC = 18;
	localparam int STEP_W    = 20;
	localparam int RELAX_W   = 19;
	localparam logic [RELAX_W-1:0] ONE_STEP = RELAX_W'(1) << STEP_FRAC;

	// configuration port
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = STEP_W;
	localparam logic [CFG_IDX_W-1:0] CFG_STEP_A   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_STEP_B   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_RELAX    = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_COPY_OLD = 2'd3;

	// square root unit: magnitudes are scaled up to this many bits first
	localparam int RAD_BASE = 60;
	localparam int RAD_W    = 64;
	localparam int ROOT_W   = RAD_W / 2;
	localparam int REM_W    = ROOT_W + 4;

	typedef struct packed {
		logic [RAD_W-1:0]  rad;
		logic [REM_W-1:0]  rem;
		logic [ROOT_W-1:0] q;
	} root_t;

	// one result bit of the digit-by-digit square root
	function automatic root_t root_step(input root_t x);
		root_t y;
		logic [REM_W-1:0] t;
		logic [REM_W-1:0] trial;
		t     = {x.rem[REM_W-3:0], x.rad[RAD_W-1 -: 2]};
		trial = REM_W'({x.q, 2'b01});
		y.rad = {x.rad[RAD_W-3:0], 2'b00};
		if (t >= trial) begin
			y.rem = t - trial;
			y.q   = {x.q[ROOT_W-2:0], 1'b1};
		end else begin
			y.rem = t;
			y.q   = {x.q[ROOT_W-2:0], 1'b0};
		end
		return y;
	endfunction

endpackage

FILE: sv/vpu_if.sv
`timescale 1ns / 1ps

interface vpu_particle_if import vpu_pkg::*; #(
	parameter int CW = DEF_COMPONENT_WIDTH
);
	logic            valid;
	logic            ready;
	logic [3*CW-1:0] position;
	logic [3*CW-1:0] velocity;
	logic [3*CW-1:0] velocity_prev;
	logic [3*CW-1:0] strength;
	logic [3*CW-1:0] stretch_rate;
	logic [3*CW-1:0] stretch_rate_prev;
	logic [3*CW-1:0] grad_row0;
	logic [3*CW-1:0] grad_row1;
	logic [3*CW-1:0] grad_row2;
	logic            last_in;

	modport source (output valid, position, velocity, velocity_prev, strength, stretch_rate,
		stretch_rate_prev, grad_row0, grad_row1, grad_row2, last_in, input ready);
	modport sink (input valid, position, velocity, velocity_prev, strength, stretch_rate,
		stretch_rate_prev, grad_row0, grad_row1, grad_row2, last_in, output ready);
endinterface

interface vpu_result_if import vpu_pkg::*; #(
	parameter int CW = DEF_COMPONENT_WIDTH
);
	logic            valid;
	logic            ready;
	logic [3*CW-1:0] new_position;
	logic [3*CW-1:0] new_velocity_prev;
	logic [3*CW-1:0] new_strength;
	logic [3*CW-1:0] new_stretch_rate;
	logic [3*CW-1:0] new_stretch_rate_prev;
	logic            overflow;
	logic            last_out;

	modport source (output valid, new_position, new_velocity_prev, new_strength,
		new_stretch_rate, new_stretch_rate_prev, overflow, last_out, input ready);
	modport sink (input valid, new_position, new_velocity_prev, new_strength,
		new_stretch_rate, new_stretch_rate_prev, overflow, last_out, output ready);
endinterface

interface vpu_cfg_if import vpu_pkg::*;;
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

FILE: sv/vortex_particle_update.sv
`timescale 1ns / 1ps

// Vortex particle time step: one particle word in, one advanced particle word out, one word
// per clock sustained while the result side accepts words. The pipeline holds five stages
// of products and sums, a 32-stage square root pipeline for the strength and vorticity
// magnitudes, one scaling multiply, a COMPONENT_WIDTH + 2 stage restoring divider for the
// relaxation target, and four stages of relaxation, integration and saturation. All stages
// advance together; while a finished word waits on the result side, the pipeline and the
// particle side hold. Configuration writes are always taken, but belong only to idle
// periods.
module vortex_particle_update import vpu_pkg::*; #(
	parameter int COMPONENT_WIDTH = DEF_COMPONENT_WIDTH,
	parameter int FRACTION_BITS   = DEF_FRACTION_BITS
) (
	input  logic           clk,
	input  logic           arst_n,
	vpu_cfg_if.sink        cfg,
	vpu_particle_if.sink   particle,
	vpu_result_if.source   result
);

	localparam int C      = COMPONENT_WIDTH;
	localparam int F      = FRACTION_BITS;
	localparam int VW     = 3 * C;
	localparam int SF     = STEP_FRAC;
	localparam int SW     = STEP_W;
	localparam int PRD_W  = SW + C;
	localparam int PACC_W = SW + C + 2;
	localparam int NDW    = 2 * C + F;
	localparam int W_W    = C + 1;
	localparam int SQ_W   = 2 * C + 2;
	localparam int RS     = RAD_BASE - 2 * C;
	localparam int PRE_W  = SW + C + 1;
	localparam int MAG_W  = C + 1;
	localparam int QW     = C + 2;
	localparam int DV_W   = MAG_W + ROOT_W + 1;
	localparam int TW     = QW + 1;
	localparam int OMR_W  = RELAX_W + 1;
	localparam int RX_W   = C + SF + 4;
	localparam int SP_W   = RX_W - SF;
	localparam int FIN_W  = C + SF + 6;

	localparam logic signed [63:0] CMAX64 = (64'sd1 <<< (C - 1)) - 64'sd1;
	localparam logic signed [63:0] CMIN64 = -CMAX64 - 64'sd1;
	localparam logic [C-1:0] CMAX_C = {1'b0, {(C-1){1'b1}}};
	localparam logic [C-1:0] CMIN_C = {1'b1, {(C-1){1'b0}}};

	typedef struct packed {
		logic [VW-1:0]             np;
		logic                      ov;
		logic [VW-1:0]             vpo;
		logic [VW-1:0]             nd;
		logic [VW-1:0]             srpo;
		logic [2:0][PRE_W-1:0]     pre;
		logic [VW-1:0]             s;
		logic [2:0][W_W-1:0]       w;
		logic                      wz;
		logic                      last;
	} side_t;

	function automatic logic signed [C-1:0] cmp(input logic [VW-1:0] v, input int k);
		return signed'(v[k*C +: C]);
	endfunction

	// {saturated, value}
	function automatic logic [C:0] sat_c(input logic signed [63:0] v);
		if (v > CMAX64)
			return {1'b1, CMAX_C};
		if (v < CMIN64)
			return {1'b1, CMIN_C};
		return {1'b0, v[C-1:0]};
	endfunction

	// configuration
	logic signed [SW-1:0] step_a_q;
	logic signed [SW-1:0] step_b_q;
	logic [RELAX_W-1:0]   relax_q;
	logic                 copy_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_a_q <= '0;
			step_b_q <= '0;
			relax_q  <= '0;
			copy_q   <= 1'b0;
		end else if (cfg.valid) begin
			case (cfg.index)
				CFG_STEP_A:   step_a_q <= signed'(cfg.data[SW-1:0]);
				CFG_STEP_B:   step_b_q <= signed'(cfg.data[SW-1:0]);
				CFG_RELAX:    relax_q  <= cfg.data[RELAX_W-1:0];
				CFG_COPY_OLD: copy_q   <= cfg.data[0];
				default: ;
			endcase
		end
	end

	logic en;
	logic v_s9;
	assign en = !v_s9 || result.ready;
	assign particle.ready = en;

	logic [VW-1:0] grow [3];
	assign grow[0] = particle.grad_row0;
	assign grow[1] = particle.grad_row1;
	assign grow[2] = particle.grad_row2;

	// stage 1: products and vorticity
	logic                    v_s1;
	logic signed [C-1:0]     pp_s1 [3];
	logic signed [PRD_W-1:0] pa_s1 [3];
	logic signed [PRD_W-1:0] pb_s1 [3];
	logic signed [2*C-1:0]   gs_s1 [3][3];
	logic signed [W_W-1:0]   w_s1 [3];
	logic signed [2*C-1:0]   ssq_s1 [3];
	logic [VW-1:0]           s_s1, sr_s1, srp_s1, vpo_s1;
	logic                    last_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				pp_s1[i]  <= cmp(particle.position, i);
				pa_s1[i]  <= step_a_q * cmp(particle.velocity, i);
				pb_s1[i]  <= step_b_q * cmp(particle.velocity_prev, i);
				ssq_s1[i] <= cmp(particle.strength, i) * cmp(particle.strength, i);
				for (int j = 0; j < 3; j++)
					gs_s1[j][i] <= cmp(grow[i], j) * cmp(particle.strength, i);
			end
			w_s1[0] <= W_W'(cmp(grow[2], 1)) - W_W'(cmp(grow[1], 2));
			w_s1[1] <= W_W'(cmp(grow[0], 2)) - W_W'(cmp(grow[2], 0));
			w_s1[2] <= W_W'(cmp(grow[1], 0)) - W_W'(cmp(grow[0], 1));
			s_s1    <= particle.strength;
			sr_s1   <= particle.stretch_rate;
			srp_s1  <= particle.stretch_rate_prev;
			vpo_s1  <= copy_q ? particle.velocity : particle.velocity_prev;
			last_s1 <= particle.last_in;
		end
	end

	// stage 2: sums and squares
	logic                     v_s2;
	logic signed [PACC_W-1:0] pacc_s2 [3];
	logic signed [NDW-1:0]    ndacc_s2 [3];
	logic signed [2*W_W-1:0]  wsq_s2 [3];
	logic [SQ_W-1:0]          ssum_s2;
	logic signed [W_W-1:0]    w_s2 [3];
	logic [VW-1:0]            s_s2, srp_s2, vpo_s2;
	logic                     last_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				pacc_s2[i]  <= (PACC_W'(pp_s1[i]) <<< SF) + PACC_W'(pa_s1[i])
					+ PACC_W'(pb_s1[i]);
				ndacc_s2[i] <= (NDW'(cmp(sr_s1, i)) <<< F) + NDW'(gs_s1[i][0])
					+ NDW'(gs_s1[i][1]) + NDW'(gs_s1[i][2]);
				wsq_s2[i]   <= w_s1[i] * w_s1[i];
				w_s2[i]     <= w_s1[i];
			end
			ssum_s2 <= SQ_W'($unsigned(ssq_s1[0])) + SQ_W'($unsigned(ssq_s1[1]))
				+ SQ_W'($unsigned(ssq_s1[2]));
			s_s2    <= s_s1;
			srp_s2  <= srp_s1;
			vpo_s2  <= vpo_s1;
			last_s2 <= last_s1;
		end
	end

	// stage 3: round and saturate position and stretching rate, sum the vorticity squares
	logic [VW-1:0] np_d, nd_d;
	logic          ov_d;

	always_comb begin
		logic signed [PACC_W-1:0] tp;
		logic signed [NDW-1:0]    tn;
		logic [C:0]               rp;
		logic [C:0]               rn;
		np_d = '0;
		nd_d = '0;
		ov_d = 1'b0;
		for (int i = 0; i < 3; i++) begin
			tp = (pacc_s2[i] + (PACC_W'(1) <<< (SF - 1))) >>> SF;
			tn = (ndacc_s2[i] + (NDW'(1) <<< (F - 1))) >>> F;
			rp = sat_c(64'(tp));
			rn = sat_c(64'(tn));
			np_d[i*C +: C] = rp[C-1:0];
			nd_d[i*C +: C] = rn[C-1:0];
			ov_d = ov_d | rp[C];
		end
	end

	logic                  v_s3;
	logic [VW-1:0]         np_s3, nd_s3, s_s3, srp_s3, vpo_s3;
	logic                  ov_s3;
	logic [SQ_W-1:0]       wsum_s3, ssum_s3;
	logic [2:0][W_W-1:0]   w_s3;
	logic                  last_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			np_s3   <= np_d;
			nd_s3   <= nd_d;
			ov_s3   <= ov_d;
			wsum_s3 <= SQ_W'($unsigned(wsq_s2[0])) + SQ_W'($unsigned(wsq_s2[1]))
				+ SQ_W'($unsigned(wsq_s2[2]));
			ssum_s3 <= ssum_s2;
			for (int i = 0; i < 3; i++)
				w_s3[i] <= w_s2[i];
			s_s3    <= s_s2;
			srp_s3  <= srp_s2;
			vpo_s3  <= vpo_s2;
			last_s3 <= last_s2;
		end
	end

	// stage 4: integration products, root radicands
	logic                    v_s4;
	logic signed [PRD_W-1:0] pa2_s4 [3];
	logic signed [PRD_W-1:0] pb2_s4 [3];
	logic [RAD_W-1:0]        rads_s4, radw_s4;
	logic                    wz_s4, ov_s4;
	logic [VW-1:0]           np_s4, nd_s4, srpo_s4, s_s4, vpo_s4;
	logic [2:0][W_W-1:0]     w_s4;
	logic                    last_s4;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				pa2_s4[i] <= step_a_q * cmp(nd_s3, i);
				pb2_s4[i] <= step_b_q * cmp(srp_s3, i);
			end
			rads_s4 <= RAD_W'(ssum_s3) << RS;
			radw_s4 <= RAD_W'(wsum_s3) << RS;
			wz_s4   <= (wsum_s3 == '0);
			srpo_s4 <= copy_q ? nd_s3 : srp_s3;
			np_s4   <= np_s3;
			ov_s4   <= ov_s3;
			nd_s4   <= nd_s3;
			s_s4    <= s_s3;
			w_s4    <= w_s3;
			vpo_s4  <= vpo_s3;
			last_s4 <= last_s3;
		end
	end

	// stage 5 is root stage 0; square roots follow, one bit per stage
	logic  root_v_s    [ROOT_W+1];
	side_t root_side_s [ROOT_W+1];
	root_t root_sa_s   [ROOT_W+1];
	root_t root_wa_s   [ROOT_W+1];

	always_ff @(posedge clk) begin
		if (en) begin
			root_side_s[0].np   <= np_s4;
			root_side_s[0].ov   <= ov_s4;
			root_side_s[0].vpo  <= vpo_s4;
			root_side_s[0].nd   <= nd_s4;
			root_side_s[0].srpo <= srpo_s4;
			for (int i = 0; i < 3; i++)
				root_side_s[0].pre[i] <= PRE_W'(pa2_s4[i]) + PRE_W'(pb2_s4[i]);
			root_side_s[0].s    <= s_s4;
			root_side_s[0].w    <= w_s4;
			root_side_s[0].wz   <= wz_s4;
			root_side_s[0].last <= last_s4;
			root_sa_s[0]        <= '{rad: rads_s4, rem: '0, q: '0};
			root_wa_s[0]        <= '{rad: radw_s4, rem: '0, q: '0};
		end
	end

	for (genvar k = 0; k < ROOT_W; k++) begin : g_root
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				root_v_s[k+1] <= 1'b0;
			else if (en)
				root_v_s[k+1] <= root_v_s[k];
		end

		always_ff @(posedge clk) begin
			if (en) begin
				root_side_s[k+1] <= root_side_s[k];
				root_sa_s[k+1]   <= root_step(root_sa_s[k]);
				root_wa_s[k+1]   <= root_step(root_wa_s[k]);
			end
		end
	end

	// divider stage 0: scale each vorticity magnitude by |S| and add half of |w|
	logic              div_v_s    [QW+1];
	side_t             div_side_s [QW+1];
	logic [DV_W-1:0]   div_rem_s  [QW+1][3];
	logic [QW-1:0]     div_q_s    [QW+1][3];
	logic [ROOT_W-1:0] div_wn_s   [QW+1];

	logic [ROOT_W-1:0] sn, wn1;
	logic [DV_W-1:0]   num_d [3];

	always_comb begin
		logic signed [W_W-1:0]     wv;
		logic [MAG_W-1:0]          mag;
		logic [MAG_W+ROOT_W-1:0]   prod;
		sn  = root_sa_s[ROOT_W].q;
		wn1 = (root_wa_s[ROOT_W].q == '0) ? ROOT_W'(1) : root_wa_s[ROOT_W].q;
		for (int i = 0; i < 3; i++) begin
			wv       = signed'(root_side_s[ROOT_W].w[i]);
			mag      = MAG_W'(wv[W_W-1] ? -wv : wv);
			prod     = mag * sn;
			num_d[i] = DV_W'(prod) + DV_W'(wn1 >> 1);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			div_side_s[0] <= root_side_s[ROOT_W];
			div_wn_s[0]   <= wn1;
			for (int i = 0; i < 3; i++) begin
				div_rem_s[0][i] <= num_d[i];
				div_q_s[0][i]   <= '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			div_v_s[0] <= 1'b0;
		else if (en)
			div_v_s[0] <= root_v_s[ROOT_W];
	end

	// restoring division, most significant quotient bit first
	for (genvar k = 0; k < QW; k++) begin : g_div
		localparam int B = QW - 1 - k;
		logic [DV_W-1:0] dvs;
		assign dvs = DV_W'(div_wn_s[k]) << B;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				div_v_s[k+1] <= 1'b0;
			else if (en)
				div_v_s[k+1] <= div_v_s[k];
		end

		always_ff @(posedge clk) begin
			if (en) begin
				div_side_s[k+1] <= div_side_s[k];
				div_wn_s[k+1]   <= div_wn_s[k];
				for (int i = 0; i < 3; i++) begin
					div_rem_s[k+1][i] <= (div_rem_s[k][i] >= dvs)
						? div_rem_s[k][i] - dvs : div_rem_s[k][i];
					div_q_s[k+1][i]   <= {div_q_s[k][i][QW-2:0], div_rem_s[k][i] >= dvs};
				end
			end
		end
	end

	// stage 6: relaxation products
	logic [RELAX_W-1:0]  reff, omr;
	logic signed [TW-1:0] tval [3];

	always_comb begin
		logic signed [TW-1:0] qs;
		reff = (relax_q > ONE_STEP) ? ONE_STEP : relax_q;
		omr  = ONE_STEP - reff;
		for (int i = 0; i < 3; i++) begin
			qs      = signed'({1'b0, div_q_s[QW][i]});
			tval[i] = div_side_s[QW].w[i][W_W-1] ? -qs : qs;
		end
	end

	logic                        v_s6;
	logic signed [OMR_W+C-1:0]   po_s6 [3];
	logic signed [OMR_W+TW-1:0]  pr_s6 [3];
	side_t                       side_s6;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				po_s6[i] <= signed'({1'b0, omr}) * cmp(div_side_s[QW].s, i);
				pr_s6[i] <= signed'({1'b0, reff}) * tval[i];
			end
			side_s6 <= div_side_s[QW];
		end
	end

	// stage 7: relaxed strength, unsaturated
	logic signed [SP_W-1:0] sp_d [3];

	always_comb begin
		logic signed [RX_W-1:0] rx;
		for (int i = 0; i < 3; i++) begin
			rx = (RX_W'(po_s6[i]) + RX_W'(pr_s6[i]) + (RX_W'(1) <<< (SF - 1))) >>> SF;
			sp_d[i] = side_s6.wz ? SP_W'(cmp(side_s6.s, i)) : SP_W'(rx);
		end
	end

	logic                   v_s7;
	logic signed [SP_W-1:0] sp_s7 [3];
	side_t                  side_s7;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++)
				sp_s7[i] <= sp_d[i];
			side_s7 <= side_s6;
		end
	end

	// stage 8: integrate strength
	logic                    v_s8;
	logic signed [FIN_W-1:0] fin_s8 [3];
	side_t                   side_s8;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++)
				fin_s8[i] <= (FIN_W'(sp_s7[i]) <<< SF) + FIN_W'(signed'(side_s7.pre[i]))
					+ (FIN_W'(1) <<< (SF - 1));
			side_s8 <= side_s7;
		end
	end

	// stage 9: round, saturate, output register
	logic [VW-1:0] ns_d;

	always_comb begin
		logic signed [FIN_W-1:0] tf;
		logic [C:0]              rf;
		ns_d = '0;
		for (int i = 0; i < 3; i++) begin
			tf = fin_s8[i] >>> SF;
			rf = sat_c(64'(tf));
			ns_d[i*C +: C] = rf[C-1:0];
		end
	end

	logic [VW-1:0] np_s9, vpo_s9, ns_s9, nd_s9, srpo_s9;
	logic          ov_s9, last_s9;

	always_ff @(posedge clk) begin
		if (en) begin
			np_s9   <= side_s8.np;
			vpo_s9  <= side_s8.vpo;
			ns_s9   <= ns_d;
			nd_s9   <= side_s8.nd;
			srpo_s9 <= side_s8.srpo;
			ov_s9   <= side_s8.ov;
			last_s9 <= side_s8.last;
		end
	end

	// valid bits of the linear stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			v_s4        <= 1'b0;
			root_v_s[0] <= 1'b0;
			v_s6        <= 1'b0;
			v_s7        <= 1'b0;
			v_s8        <= 1'b0;
			v_s9        <= 1'b0;
		end else if (en) begin
			v_s1        <= particle.valid;
			v_s2        <= v_s1;
			v_s3        <= v_s2;
			v_s4        <= v_s3;
			root_v_s[0] <= v_s4;
			v_s6        <= div_v_s[QW];
			v_s7        <= v_s6;
			v_s8        <= v_s7;
			v_s9        <= v_s8;
		end
	end

	assign result.valid                 = v_s9;
	assign result.new_position          = np_s9;
	assign result.new_velocity_prev     = vpo_s9;
	assign result.new_strength          = ns_s9;
	assign result.new_stretch_rate      = nd_s9;
	assign result.new_stretch_rate_prev = srpo_s9;
	assign result.overflow              = ov_s9;
	assign result.last_out              = last_s9;

	a_stall_only_from_output: assert property (@(posedge clk) disable iff (!arst_n)
		!particle.ready |-> (result.valid && !result.ready))
		else $error("particle side held without a result stall");

	a_root_remainder: assert property (@(posedge clk) disable iff (!arst_n)
		root_v_s[ROOT_W] |-> (root_sa_s[ROOT_W].rem <= REM_W'({root_sa_s[ROOT_W].q, 1'b0}))
			&& (root_wa_s[ROOT_W].rem <= REM_W'({root_wa_s[ROOT_W].q, 1'b0})))
		else $error("square root remainder out of range");

	a_div_range: assert property (@(posedge clk) disable iff (!arst_n)
		(div_v_s[0] && !div_side_s[0].wz) |->
			(div_rem_s[0][0] < (DV_W'(div_wn_s[0]) << QW))
			&& (div_rem_s[0][1] < (DV_W'(div_wn_s[0]) << QW))
			&& (div_rem_s[0][2] < (DV_W'(div_wn_s[0]) << QW)))
		else $error("relaxation quotient exceeds divider width");

	a_overflow_saturates: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && result.overflow) |->
			(result.new_position[0 +: C] == CMAX_C) || (result.new_position[0 +: C] == CMIN_C)
			|| (result.new_position[C +: C] == CMAX_C)
			|| (result.new_position[C +: C] == CMIN_C)
			|| (result.new_position[2*C +: C] == CMAX_C)
			|| (result.new_position[2*C +: C] == CMIN_C))
		else $error("overflow flagged without a saturated position component");

endmodule

FILE: tb/sv/tb_vortex_particle_update.sv
`timescale 1ns / 1ps

module tb_vortex_particle_update import vpu_pkg::*;;

	localparam int CW    = DEF_COMPONENT_WIDTH;
	localparam int FB    = DEF_FRACTION_BITS;
	localparam int LAT   = CW + 44;
	localparam int N_RND = 1800;

	typedef logic [3*CW-1:0] vec_t;

	typedef struct packed {
		vec_t position;
		vec_t velocity;
		vec_t velocity_prev;
		vec_t strength;
		vec_t stretch_rate;
		vec_t stretch_rate_prev;
		vec_t grad_row0;
		vec_t grad_row1;
		vec_t grad_row2;
		logic last_in;
	} particle_t;

	typedef struct packed {
		vec_t new_position;
		vec_t new_velocity_prev;
		vec_t new_strength;
		vec_t new_stretch_rate;
		vec_t new_stretch_rate_prev;
		logic overflow;
		logic last_out;
	} advanced_t;

	typedef struct {
		particle_t p;
		logic      has_known;
		advanced_t known;
	} stim_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	vpu_cfg_if      cfg ();
	vpu_particle_if #(.CW(CW)) particle ();
	vpu_result_if   #(.CW(CW)) result ();

	vortex_particle_update u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg.sink),
		.particle (particle.sink),
		.result   (result.source)
	);

	always #2 clk = ~clk;

	// model copy of the register file
	logic signed [STEP_W-1:0] w_cur;
	logic signed [STEP_W-1:0] w_old;
	logic [RELAX_W-1:0]       relax_frac;
	logic                     copy_prev;

	advanced_t expected_q[$];
	int        errors = 0;
	int        rx_count = 0;
	int        hold_off = 0;
	logic      quiet_rx = 1'b0;
	logic      quiet_tx = 1'b0;

	function automatic longint comp_of(vec_t v, int k);
		logic signed [CW-1:0] c;
		c = v[k*CW +: CW];
		return longint'(c);
	endfunction

	// round half toward plus infinity
	function automatic longint round_up(longint v, int s);
		return (v + (longint'(1) << (s - 1))) >>> s;
	endfunction

	function automatic longint clamp(longint v, ref logic hit);
		longint hi;
		hi = (longint'(1) <<< (CW - 1)) - 1;
		if (v > hi) begin
			hit = 1'b1;
			return hi;
		end
		if (v < -hi - 1) begin
			hit = 1'b1;
			return -hi - 1;
		end
		return v;
	endfunction

	function automatic longint unsigned int_root(longint unsigned x);
		longint unsigned r, bitv;
		r = 0;
		bitv = 64'd1 << 62;
		while (bitv > x)
			bitv >>= 2;
		while (bitv != 0) begin
			if (x >= r + bitv) begin
				x -= r + bitv;
				r = (r >> 1) + bitv;
			end else begin
				r >>= 1;
			end
			bitv >>= 2;
		end
		return r;
	endfunction

	function automatic advanced_t advance_particle(particle_t p);
		advanced_t o;
		longint a, b, r, acc, t, one;
		longint g[3][3];
		longint s[3], np[3], nd[3], ns[3], w[3];
		longint unsigned s2, w2, sn, wn, mag;
		logic ov, junk;
		vec_t rows[3];
		one = longint'(1) << STEP_FRAC;
		a = longint'(w_cur);
		b = longint'(w_old);
		r = longint'(relax_frac);
		ov = 1'b0;
		junk = 1'b0;
		s2 = 0;
		w2 = 0;
		if (r > one)
			r = one;
		rows[0] = p.grad_row0;
		rows[1] = p.grad_row1;
		rows[2] = p.grad_row2;
		for (int i = 0; i < 3; i++) begin
			for (int j = 0; j < 3; j++)
				g[i][j] = comp_of(rows[i], j);
			s[i] = comp_of(p.strength, i);
		end
		for (int i = 0; i < 3; i++) begin
			acc = comp_of(p.position, i) * one + a * comp_of(p.velocity, i)
				+ b * comp_of(p.velocity_prev, i);
			np[i] = clamp(round_up(acc, STEP_FRAC), ov);
		end
		for (int j = 0; j < 3; j++) begin
			acc = comp_of(p.stretch_rate, j) * (longint'(1) << FB);
			for (int i = 0; i < 3; i++)
				acc += g[i][j] * s[i];
			nd[j] = clamp(round_up(acc, FB), junk);
		end
		w[0] = g[2][1] - g[1][2];
		w[1] = g[0][2] - g[2][0];
		w[2] = g[1][0] - g[0][1];
		for (int i = 0; i < 3; i++) begin
			w2 += longint'(w[i] * w[i]);
			s2 += longint'(s[i] * s[i]);
		end
		if (w2 != 0) begin
			sn = int_root(s2 << (RAD_BASE - 2 * CW));
			wn = int_root(w2 << (RAD_BASE - 2 * CW));
			if (wn == 0)
				wn = 1;
			for (int i = 0; i < 3; i++) begin
				mag = (w[i] < 0) ? -w[i] : w[i];
				t = longint'((mag * sn + wn / 2) / wn);
				if (w[i] < 0)
					t = -t;
				s[i] = round_up((one - r) * s[i] + r * t, STEP_FRAC);
			end
		end
		for (int i = 0; i < 3; i++) begin
			acc = s[i] * one + a * nd[i] + b * comp_of(p.stretch_rate_prev, i);
			ns[i] = clamp(round_up(acc, STEP_FRAC), junk);
		end
		for (int i = 0; i < 3; i++) begin
			o.new_position[i*CW +: CW]     = np[i][CW-1:0];
			o.new_strength[i*CW +: CW]     = ns[i][CW-1:0];
			o.new_stretch_rate[i*CW +: CW] = nd[i][CW-1:0];
		end
		o.new_velocity_prev     = copy_prev ? p.velocity : p.velocity_prev;
		o.new_stretch_rate_prev = copy_prev ? o.new_stretch_rate : p.stretch_rate_prev;
		o.overflow              = ov;
		o.last_out              = p.last_in;
		return o;
	endfunction

	function automatic vec_t pack3(int x, int y, int z);
		vec_t v;
		v[0 +: CW]    = x[CW-1:0];
		v[CW +: CW]   = y[CW-1:0];
		v[2*CW +: CW] = z[CW-1:0];
		return v;
	endfunction

	// mostly modest components so the sums stay in range, sometimes full width
	function automatic vec_t rand_vec();
		vec_t v;
		int mode;
		mode = $urandom_range(0, 9);
		for (int k = 0; k < 3; k++) begin
			if (mode < 2)
				v[k*CW +: CW] = CW'($urandom);
			else if (mode == 2)
				v[k*CW +: CW] = '0;
			else
				v[k*CW +: CW] = CW'($signed($urandom_range(0, 16384)) - 8192);
		end
		return v;
	endfunction

	function automatic particle_t rand_particle();
		particle_t p;
		p.position          = rand_vec();
		p.velocity          = rand_vec();
		p.velocity_prev     = rand_vec();
		p.strength          = rand_vec();
		p.stretch_rate      = rand_vec();
		p.stretch_rate_prev = rand_vec();
		p.grad_row0         = rand_vec();
		p.grad_row1         = rand_vec();
		p.grad_row2         = rand_vec();
		// symmetric gradient gives zero vorticity
		if ($urandom_range(0, 7) == 0) begin
			p.grad_row1[0 +: CW]    = p.grad_row0[CW +: CW];
			p.grad_row2[0 +: CW]    = p.grad_row0[2*CW +: CW];
			p.grad_row2[CW +: CW]   = p.grad_row1[2*CW +: CW];
		end
		p.last_in = 1'($urandom_range(0, 1));
		return p;
	endfunction

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data  <= val;
		@(posedge clk);
		while (!cfg.ready)
			@(posedge clk);
		cfg.valid <= 1'b0;
		case (idx)
			CFG_STEP_A:   w_cur = val;
			CFG_STEP_B:   w_old = val;
			CFG_RELAX:    relax_frac = val[RELAX_W-1:0];
			CFG_COPY_OLD: copy_prev = val[0];
			default: ;
		endcase
	endtask

	task automatic set_regs(int a, int b, int r, int c);
		write_reg(CFG_STEP_A, a[CFG_DATA_W-1:0]);
		write_reg(CFG_STEP_B, b[CFG_DATA_W-1:0]);
		write_reg(CFG_RELAX, r[CFG_DATA_W-1:0]);
		write_reg(CFG_COPY_OLD, c[CFG_DATA_W-1:0]);
	endtask

	// offer one word; queue its prediction on acceptance
	task automatic send_particle(particle_t p, logic has_known, advanced_t known);
		while (!quiet_tx && $urandom_range(0, 99) < 22) begin
			particle.valid <= 1'b0;
			@(posedge clk);
		end
		particle.valid             <= 1'b1;
		particle.position          <= p.position;
		particle.velocity          <= p.velocity;
		particle.velocity_prev     <= p.velocity_prev;
		particle.strength          <= p.strength;
		particle.stretch_rate      <= p.stretch_rate;
		particle.stretch_rate_prev <= p.stretch_rate_prev;
		particle.grad_row0         <= p.grad_row0;
		particle.grad_row1         <= p.grad_row1;
		particle.grad_row2         <= p.grad_row2;
		particle.last_in           <= p.last_in;
		@(posedge clk);
		while (!particle.ready)
			@(posedge clk);
		expected_q.push_back(has_known ? known : advance_particle(p));
	endtask

	task automatic drain();
		particle.valid <= 1'b0;
		while (expected_q.size() != 0)
			@(posedge clk);
		repeat (LAT + 8) @(posedge clk);
	endtask

	// result side
	always @(posedge clk) begin
		if (hold_off > 0) begin
			hold_off <= hold_off - 1;
			result.ready <= 1'b0;
		end else begin
			result.ready <= quiet_rx ? 1'b1 : ($urandom_range(0, 99) >= 22);
		end
	end

	always @(posedge clk) begin
		advanced_t got, want;
		if (arst_n && result.valid && result.ready) begin
			got.new_position          = result.new_position;
			got.new_velocity_prev     = result.new_velocity_prev;
			got.new_strength          = result.new_strength;
			got.new_stretch_rate      = result.new_stretch_rate;
			got.new_stretch_rate_prev = result.new_stretch_rate_prev;
			got.overflow              = result.overflow;
			got.last_out              = result.last_out;
			if (expected_q.size() == 0) begin
				$display("%t: unexpected word, actual %h", $realtime, got);
				errors++;
			end else begin
				want = expected_q.pop_front();
				rx_count++;
				if (got.new_position !== want.new_position) begin
					$display("%t: new_position expected %h actual %h", $realtime,
						want.new_position, got.new_position);
					errors++;
				end
				if (got.new_velocity_prev !== want.new_velocity_prev) begin
					$display("%t: new_velocity_prev expected %h actual %h", $realtime,
						want.new_velocity_prev, got.new_velocity_prev);
					errors++;
				end
				if (got.new_strength !== want.new_strength) begin
					$display("%t: new_strength expected %h actual %h", $realtime,
						want.new_strength, got.new_strength);
					errors++;
				end
				if (got.new_stretch_rate !== want.new_stretch_rate) begin
					$display("%t: new_stretch_rate expected %h actual %h", $realtime,
						want.new_stretch_rate, got.new_stretch_rate);
					errors++;
				end
				if (got.new_stretch_rate_prev !== want.new_stretch_rate_prev) begin
					$display("%t: new_stretch_rate_prev expected %h actual %h", $realtime,
						want.new_stretch_rate_prev, got.new_stretch_rate_prev);
					errors++;
				end
				if (got.overflow !== want.overflow) begin
					$display("%t: overflow expected %b actual %b", $realtime,
						want.overflow, got.overflow);
					errors++;
				end
				if (got.last_out !== want.last_out) begin
					$display("%t: last_out expected %b actual %b", $realtime,
						want.last_out, got.last_out);
					errors++;
				end
			end
		end
	end

	initial begin
		#2000000;
		$display("DONE: errors detected");
		$finish;
	end

	initial begin
		stim_row_t rows[$];
		particle_t p;
		advanced_t k;
		vec_t vmax, vmin, ones;

		cfg.valid = 1'b0;
		cfg.index = '0;
		cfg.data = '0;
		particle.valid = 1'b0;
		particle.position = '0;
		particle.velocity = '0;
		particle.velocity_prev = '0;
		particle.strength = '0;
		particle.stretch_rate = '0;
		particle.stretch_rate_prev = '0;
		particle.grad_row0 = '0;
		particle.grad_row1 = '0;
		particle.grad_row2 = '0;
		particle.last_in = 1'b0;
		result.ready = 1'b0;
		w_cur = '0;
		w_old = '0;
		relax_frac = '0;
		copy_prev = 1'b0;

		vmax = pack3(524287, 524287, 524287);
		vmin = pack3(-524288, -524288, -524288);
		ones = pack3(4096, 4096, 4096);

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// after reset: weights zero, so the particle passes through unchanged
		p = '0;
		p.position = vmax;
		p.velocity = ones;
		p.velocity_prev = vmin;
		p.strength = pack3(100, -200, 300);
		p.stretch_rate = pack3(7, 8, 9);
		p.stretch_rate_prev = pack3(-1, -2, -3);
		p.last_in = 1'b1;
		k = '0;
		k.new_position = vmax;
		k.new_velocity_prev = vmin;
		k.new_strength = pack3(100, -200, 300);
		k.new_stretch_rate = pack3(7, 8, 9);
		k.new_stretch_rate_prev = pack3(-1, -2, -3);
		k.last_out = 1'b1;
		rows.push_back('{p, 1'b1, k});
		p = '0;
		rows.push_back('{p, 1'b1, '0});
		foreach (rows[i])
			send_particle(rows[i].p, rows[i].has_known, rows[i].known);
		drain();
		rows.delete();

		// extremes: step of one drives position to saturation, copy on, full relaxation
		set_regs(262144, 524287, 262144, 1);
		p = '0;
		p.position = vmax;
		p.velocity = ones;
		rows.push_back('{p, 1'b0, '0});
		p.position = vmin;
		p.velocity = vmin;
		p.velocity_prev = vmin;
		rows.push_back('{p, 1'b0, '0});
		p = '0;
		p.strength = vmax;
		p.grad_row0 = vmin;
		p.grad_row1 = vmax;
		p.grad_row2 = vmin;
		p.stretch_rate = vmax;
		p.stretch_rate_prev = vmin;
		rows.push_back('{p, 1'b0, '0});
		p = '0;
		p.strength = pack3(4096, 0, 0);
		p.grad_row1 = pack3(4096, 0, 0);
		rows.push_back('{p, 1'b0, '0});
		p.grad_row1 = pack3(0, 0, 1);
		rows.push_back('{p, 1'b0, '0});
		p.strength = '0;
		rows.push_back('{p, 1'b0, '0});
		for (int i = 0; i < 6; i++)
			rows.push_back('{rand_particle(), 1'b0, '0});
		foreach (rows[i])
			send_particle(rows[i].p, rows[i].has_known, rows[i].known);
		drain();
		rows.delete();

		// relax rate above one, negative weights, copy off
		set_regs(-524288, -1, 524287, 0);
		for (int i = 0; i < 8; i++)
			send_particle(rand_particle(), 1'b0, '0);
		drain();

		// random phases through several register settings
		for (int ph = 0; ph < 6; ph++) begin
			set_regs(int'($urandom_range(0, 1048575)) - 524288,
				(ph == 2) ? 0 : int'($urandom_range(0, 65535)) - 32768,
				int'($urandom_range(0, 270000)), int'($urandom_range(0, 1)));
			quiet_tx = (ph == 3);
			quiet_rx = (ph == 3);
			for (int i = 0; i < N_RND / 6; i++) begin
				if (ph == 1 && i == 20)
					hold_off = 3 * LAT;
				send_particle(rand_particle(), 1'b0, '0);
			end
			drain();
		end

		if (errors == 0 && expected_q.size() == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
